### hdl/brfdo_pkg.sv
// ----------------------------------------------------------------------------
// brfdo_pkg
// Shared types and constants for the drop-oldest byte ring FIFO.
// ----------------------------------------------------------------------------
package brfdo_pkg;

  // Ring geometry: one slot is always kept empty
  localparam int RING_BYTES = 1024;
  localparam int IDX_W      = $clog2(RING_BYTES);
  localparam int FILL_W     = 10;
  localparam int CNT_W      = 32;

  // Operation codes
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_UNGET = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_e;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic pop_load;  // load popped byte from memory read register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;     // ring holds no byte
    logic out_busy;  // result waiting and stalled
  } sts_t;

endpackage

### hdl/brfdo_ctrl.sv
// ----------------------------------------------------------------------------
// brfdo_ctrl
// Sequencer: accepts operations and, for byte pops, waits in a read state on the memory.
// ----------------------------------------------------------------------------
module brfdo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_kind_i,
  output logic              in_stall_o,
  input  brfdo_pkg::sts_t   sts_i,
  output brfdo_pkg::cmd_t   cmd_o
);
  import brfdo_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    in_stall_o     = 1'b1;
    cmd_o.accept   = 1'b0;
    cmd_o.pop_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = sts_i.out_busy;
        cmd_o.accept = in_valid_i && !sts_i.out_busy;
        if (cmd_o.accept && (in_kind_i == KIND_POP) && !sts_i.empty) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // read data is registered now; hand it to the output
        cmd_o.pop_load = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/brfdo_dp.sv
// ----------------------------------------------------------------------------
// brfdo_dp
// Datapath: ring memory, read/write indices, counters and result register.
// ----------------------------------------------------------------------------
module brfdo_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  brfdo_pkg::cmd_t              cmd_i,
  output brfdo_pkg::sts_t              sts_o,
  input  logic [1:0]                   in_kind_i,
  input  logic [7:0]                   in_data_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_data_out_o,
  output logic                         out_data_valid_o,
  output logic                         out_dropped_oldest_o,
  output logic                         out_refused_o,
  output logic [brfdo_pkg::FILL_W-1:0] out_fill_level_o,
  output logic [brfdo_pkg::CNT_W-1:0]  out_pushed_total_o,
  output logic [brfdo_pkg::CNT_W-1:0]  out_overflow_total_o
);
  import brfdo_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_BYTES - 1);
  localparam logic [IDX_W:0]   RING_SIZE = (IDX_W + 1)'(RING_BYTES);

  logic [7:0]       mem [RING_BYTES];
  logic [7:0]       rdata_q;

  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] pushed_q, pushed_d;
  logic [CNT_W-1:0] ovf_q, ovf_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       dout_q, dout_d;
  logic             dvalid_q, dvalid_d;
  logic             dropped_q, dropped_d;
  logic             refused_q, refused_d;

  logic [IDX_W-1:0] wr_next, rd_next, rd_prev;
  logic             full, empty;
  logic [IDX_W:0]   fill;
  logic [IDX_W+FILL_W:0] fill_ext;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;

  // Index arithmetic, modulo ring size
  assign wr_next = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
  assign rd_next = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
  assign rd_prev = (rd_idx_q == '0) ? LAST_IDX : rd_idx_q - 1'b1;
  assign full    = (wr_next == rd_idx_q);
  assign empty   = (wr_idx_q == rd_idx_q);

  // Fill level from current indices
  always_comb begin
    if (wr_idx_q >= rd_idx_q) begin
      fill = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
    end else begin
      fill = {1'b0, wr_idx_q} + RING_SIZE - {1'b0, rd_idx_q};
    end
  end
  assign fill_ext = {{FILL_W{1'b0}}, fill};

  // Operation decode
  always_comb begin
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    pushed_d    = pushed_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    dout_d      = dout_q;
    dvalid_d    = dvalid_q;
    dropped_d   = dropped_q;
    refused_d   = refused_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_idx_q;
    if (cmd_i.accept) begin
      dout_d      = '0;
      dvalid_d    = 1'b0;
      dropped_d   = 1'b0;
      refused_d   = 1'b0;
      out_valid_d = 1'b1;
      case (in_kind_i)
        KIND_PUSH: begin
          if (full) begin
            rd_idx_d  = rd_next;
            ovf_d     = ovf_q + 1'b1;
            dropped_d = 1'b1;
          end
          mem_we    = 1'b1;
          mem_waddr = wr_idx_q;
          wr_idx_d  = wr_next;
          pushed_d  = pushed_q + 1'b1;
        end
        KIND_POP: begin
          if (!empty) begin
            // result follows once the memory read lands
            rd_idx_d    = rd_next;
            out_valid_d = 1'b0;
          end
        end
        KIND_UNGET: begin
          if (full) begin
            refused_d = 1'b1;
          end else begin
            rd_idx_d  = rd_prev;
            mem_we    = 1'b1;
            mem_waddr = rd_prev;
          end
        end
        KIND_FLUSH: begin
          rd_idx_d = wr_idx_q;
        end
        default: begin
          rd_idx_d = rd_idx_q;
        end
      endcase
    end else if (cmd_i.pop_load) begin
      dout_d      = rdata_q;
      dvalid_d    = 1'b1;
      dropped_d   = 1'b0;
      refused_d   = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  // Ring memory, registered read at the read index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_data_in_i;
    end
    rdata_q <= mem[rd_idx_q];
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      pushed_q    <= '0;
      ovf_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      pushed_q    <= pushed_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    dout_q    <= dout_d;
    dvalid_q  <= dvalid_d;
    dropped_q <= dropped_d;
    refused_q <= refused_d;
  end

  // Level and totals only move on an accepted operation
  assign out_valid_o          = out_valid_q;
  assign out_data_out_o       = dout_q;
  assign out_data_valid_o     = dvalid_q;
  assign out_dropped_oldest_o = dropped_q;
  assign out_refused_o        = refused_q;
  assign out_fill_level_o     = fill_ext[FILL_W-1:0];
  assign out_pushed_total_o   = pushed_q;
  assign out_overflow_total_o = ovf_q;

  assign sts_o.empty    = empty;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

endmodule

### hdl/byte_ring_fifo_drop_oldest.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_drop_oldest
// Byte ring FIFO with drop-oldest push, pop, unget and flush operations.
// ----------------------------------------------------------------------------
// Results: push, unget, flush and empty pop give their result in the cycle after
//   the transfer; a byte pop loads its result via the registered memory read.
// Throughput: one operation per cycle while no result is stalled, except a
//   byte pop, which holds the input while the ring memory read completes.
// Reset: indices, counters and result valid clear at once; memory is not
//   cleared and needs no clearing pass.
module byte_ring_fifo_drop_oldest (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   in_kind_i,
  input  logic [7:0]                   in_data_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_data_out_o,
  output logic                         out_data_valid_o,
  output logic                         out_dropped_oldest_o,
  output logic                         out_refused_o,
  output logic [brfdo_pkg::FILL_W-1:0] out_fill_level_o,
  output logic [brfdo_pkg::CNT_W-1:0]  out_pushed_total_o,
  output logic [brfdo_pkg::CNT_W-1:0]  out_overflow_total_o
);
  import brfdo_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  brfdo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  brfdo_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .in_kind_i            (in_kind_i),
    .in_data_in_i         (in_data_in_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_data_out_o       (out_data_out_o),
    .out_data_valid_o     (out_data_valid_o),
    .out_dropped_oldest_o (out_dropped_oldest_o),
    .out_refused_o        (out_refused_o),
    .out_fill_level_o     (out_fill_level_o),
    .out_pushed_total_o   (out_pushed_total_o),
    .out_overflow_total_o (out_overflow_total_o)
  );

  // A stalled result blocks new operations
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while result stalled");

  // A byte pop shows its result after the memory read cycle
  a_pop_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && (in_kind_i == KIND_POP) && !sts.empty)
      |=> !out_valid_o ##1 (out_valid_o && out_data_valid_o))
    else $error("byte pop result timing wrong");

  // Every push bumps the pushed count by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && (in_kind_i == KIND_PUSH))
      |=> (out_valid_o && (out_pushed_total_o == $past(out_pushed_total_o) + 1'b1)))
    else $error("push count mismatch");

  // A flush leaves the ring empty
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && (in_kind_i == KIND_FLUSH)) |=> (out_valid_o && sts.empty))
    else $error("ring not empty after flush");

endmodule
